// ===== src/krbm_pkg.sv =====
// shared constants, codes and types for the keyed record best match search unit
package krbm_pkg;

  localparam int MAX_KEYS       = 4;
  localparam int MAX_ARGS       = 8;
  localparam int MAX_LINES      = 65536;
  localparam int MAX_LINE_ATOMS = 32;

  localparam int KIND_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int DIST_W     = 32;
  localparam int BEST_W     = 17;
  localparam int KEY_W      = 7;
  localparam int FIELD_W    = 4;
  localparam int OP_W       = 3;
  localparam int KCNT_W     = 3;
  localparam int KIDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = KEY_W;
  localparam int PLACE_W    = $clog2((1 << FIELD_W) + MAX_ARGS);
  localparam int POS_W      = $clog2(MAX_LINE_ATOMS) + 1;
  localparam int CMP_W      = (PLACE_W > POS_W) ? PLACE_W : POS_W;
  localparam int QCNT_W     = $clog2(MAX_ARGS) + 1;
  localparam int AIDX_W     = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
  localparam int LINE_W     = $clog2(MAX_LINES);
  localparam int LCNT_W     = LINE_W + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_START  = 3'd0,
    KIND_ARG    = 3'd1,
    KIND_ATOM   = 3'd2,
    KIND_EMPTY  = 3'd3,
    KIND_FINISH = 3'd4
  } kind_t;

  typedef enum logic [OP_W-1:0] {
    OP_EQ   = 3'd0,
    OP_GT   = 3'd1,
    OP_GE   = 3'd2,
    OP_LT   = 3'd3,
    OP_LE   = 3'd4,
    OP_NEAR = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_COUNT = 3'd0,
    CFG_KEY_0     = 3'd1,
    CFG_KEY_1     = 3'd2,
    CFG_KEY_2     = 3'd3,
    CFG_KEY_3     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TOK_NONE,
    TOK_RESTART,
    TOK_CLOSE,
    TOK_FINISH
  } tok_kind_t;

  typedef struct packed {
    logic [KCNT_W-1:0]              key_count;
    logic [MAX_KEYS-1:0][KEY_W-1:0] key;
  } krbm_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               is_symbol;
    logic [VALUE_W-1:0] value;
    logic               end_of_line;
  } krbm_item_t;

  typedef struct packed {
    tok_kind_t                       kind;
    logic                            hit;
    logic [LINE_W-1:0]               line;
    logic [MAX_ARGS-1:0]             rank;
    logic [MAX_ARGS-1:0][DIST_W-1:0] distance;
    logic                            overflow;
  } krbm_tok_t;

endpackage

// ===== src/krbm_in_if.sv =====
// input item channel
interface krbm_in_if;
  import krbm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic                      is_symbol;
  logic signed [VALUE_W-1:0] value;
  logic                      end_of_line;

  modport source (output valid, kind, is_symbol, value, end_of_line, input ready);
  modport sink (input valid, kind, is_symbol, value, end_of_line, output ready);
endinterface

// ===== src/krbm_out_if.sv =====
// result channel
interface krbm_out_if;
  import krbm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [BEST_W-1:0] best_line;
  logic                     overflow;

  modport source (output valid, best_line, overflow, input ready);
  modport sink (input valid, best_line, overflow, output ready);
endinterface

// ===== src/krbm_line_eval.sv =====
// query store and per atom line evaluation, emits one token per item
module krbm_line_eval (
  input  logic                clk,
  input  logic                rst,
  input  krbm_pkg::krbm_cfg_t  cfg,
  input  logic                item_valid,
  input  krbm_pkg::krbm_item_t item,
  input  logic                hold,
  output logic                take,
  output krbm_pkg::krbm_tok_t  tok
);
  import krbm_pkg::*;

  logic [MAX_ARGS-1:0][VALUE_W-1:0] query_value;
  logic [MAX_ARGS-1:0]              query_symbol_flag;
  logic [QCNT_W-1:0]                query_count, query_count_next;
  logic [MAX_ARGS-1:0]              arg_seen, arg_seen_next;
  logic                             line_ok, line_ok_next;
  logic [MAX_ARGS-1:0][DIST_W-1:0]  line_distance;
  logic [LCNT_W-1:0]                line_counter, line_counter_next;
  logic [POS_W-1:0]                 atom_position, atom_position_next;
  logic                             overflow_flag, overflow_flag_next;
  krbm_tok_t                        tok_next;

  logic [KCNT_W-1:0]  kc;
  logic [KEY_W-1:0]   last_key;
  logic [PLACE_W-1:0] field [MAX_ARGS];
  op_t                op [MAX_ARGS];

  logic [MAX_ARGS-1:0]             active, hit, bad, dist_wr, rank;
  logic [MAX_ARGS-1:0][DIST_W-1:0] dist_upd;
  logic [MAX_ARGS-1:0]             seen_upd;
  logic                            ok_upd, complete, lines_full, is_atom, pos_ok, arg_room;

  function automatic logic num_pass(input op_t o, input logic eq, input logic gt);
    logic p;
    case (o)
      OP_EQ:   p = eq;
      OP_GT:   p = gt;
      OP_GE:   p = gt | eq;
      OP_LT:   p = !gt && !eq;
      OP_LE:   p = !gt;
      default: p = 1'b1;
    endcase
    return p;
  endfunction

  function automatic logic key_count_zero();
    return cfg.key_count == '0;
  endfunction

  // key placement
  always_comb begin
    if (key_count_zero()) begin
      kc = KCNT_W'(1);
    end else if (cfg.key_count > KCNT_W'(MAX_KEYS)) begin
      kc = KCNT_W'(MAX_KEYS);
    end else begin
      kc = cfg.key_count;
    end
    last_key = cfg.key[KIDX_W'(kc - KCNT_W'(1))];
  end

  for (genvar j = 0; j < MAX_ARGS; j++) begin : g_arg
    logic                      eq, gt;
    logic signed [VALUE_W:0]   diff;
    logic [DIST_W-1:0]         dist_new;
    logic [PLACE_W-1:0]        tail_field;

    assign tail_field = PLACE_W'(last_key[FIELD_W-1:0]) + PLACE_W'(j + 1) - PLACE_W'(kc);

    if (j < MAX_KEYS) begin : g_own
      assign field[j] = (KCNT_W'(j) < kc) ? PLACE_W'(cfg.key[j][FIELD_W-1:0]) : tail_field;
      assign op[j]    = (KCNT_W'(j) < kc) ? op_t'(cfg.key[j][KEY_W-1:FIELD_W])
                                          : op_t'(last_key[KEY_W-1:FIELD_W]);
    end else begin : g_tail
      assign field[j] = tail_field;
      assign op[j]    = op_t'(last_key[KEY_W-1:FIELD_W]);
    end

    assign active[j] = QCNT_W'(j) < query_count;
    assign hit[j]    = is_atom && pos_ok && active[j]
                       && (CMP_W'(field[j]) == CMP_W'(atom_position));
    assign eq        = item.value == query_value[j];
    assign gt        = $signed(item.value) > $signed(query_value[j]);
    assign diff      = $signed({item.value[VALUE_W-1], item.value})
                       - $signed({query_value[j][VALUE_W-1], query_value[j]});
    assign dist_new  = diff[VALUE_W] ? DIST_W'(-diff) : diff[DIST_W-1:0];

    assign bad[j] = hit[j] && ((item.is_symbol != query_symbol_flag[j])
                    || (item.is_symbol ? ((op[j] != OP_EQ) || !eq) : !num_pass(op[j], eq, gt)));
    assign dist_wr[j]  = hit[j] && !item.is_symbol && !query_symbol_flag[j];
    assign dist_upd[j] = dist_wr[j] ? dist_new : line_distance[j];
    assign rank[j]     = active[j] && !query_symbol_flag[j] && (op[j] != OP_EQ);
  end

  assign is_atom    = item.kind == KIND_ATOM;
  assign pos_ok     = atom_position < POS_W'(MAX_LINE_ATOMS);
  assign seen_upd   = arg_seen | hit;
  assign ok_upd     = line_ok && !(|bad);
  assign complete   = (seen_upd & active) == active;
  assign lines_full = line_counter >= LCNT_W'(MAX_LINES);
  assign arg_room   = query_count < QCNT_W'(MAX_ARGS);
  assign take       = item_valid && !hold;

  always_comb begin
    logic restart, close_now;
    query_count_next   = query_count;
    arg_seen_next      = arg_seen;
    line_ok_next       = line_ok;
    line_counter_next  = line_counter;
    atom_position_next = atom_position;
    overflow_flag_next = overflow_flag;
    tok_next           = tok;
    tok_next.kind      = TOK_NONE;
    restart            = 1'b0;
    close_now          = 1'b0;

    case (item.kind)
      KIND_START: begin
        query_count_next   = '0;
        overflow_flag_next = 1'b0;
        restart            = 1'b1;
      end
      KIND_ARG: begin
        if (arg_room) begin
          query_count_next = query_count + QCNT_W'(1);
          restart          = 1'b1;
        end else begin
          overflow_flag_next = 1'b1;
        end
      end
      KIND_ATOM: begin
        arg_seen_next = seen_upd;
        line_ok_next  = ok_upd;
        if (pos_ok) begin
          atom_position_next = atom_position + POS_W'(1);
        end
        close_now = item.end_of_line;
      end
      KIND_EMPTY: begin
        close_now = 1'b1;
      end
      KIND_FINISH: begin
        tok_next.kind     = TOK_FINISH;
        tok_next.overflow = overflow_flag;
      end
      default: begin
      end
    endcase

    if (restart) begin
      tok_next.kind      = TOK_RESTART;
      arg_seen_next      = '0;
      line_ok_next       = 1'b1;
      line_counter_next  = '0;
      atom_position_next = '0;
    end

    if (close_now) begin
      tok_next.kind     = TOK_CLOSE;
      tok_next.hit      = !lines_full && ok_upd && complete;
      tok_next.line     = line_counter[LINE_W-1:0];
      tok_next.rank     = rank;
      tok_next.distance = dist_upd;
      if (lines_full) begin
        overflow_flag_next = 1'b1;
      end else begin
        line_counter_next = line_counter + LCNT_W'(1);
      end
      arg_seen_next      = '0;
      line_ok_next       = 1'b1;
      atom_position_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_count   <= '0;
      arg_seen      <= '0;
      line_ok       <= 1'b1;
      line_counter  <= '0;
      atom_position <= '0;
      overflow_flag <= 1'b0;
      tok.kind      <= TOK_NONE;
    end else if (take) begin
      query_count   <= query_count_next;
      arg_seen      <= arg_seen_next;
      line_ok       <= line_ok_next;
      line_counter  <= line_counter_next;
      atom_position <= atom_position_next;
      overflow_flag <= overflow_flag_next;
      tok           <= tok_next;
    end else if (!hold) begin
      tok.kind <= TOK_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (item.kind == KIND_ARG) && arg_room) begin
      query_value[query_count[AIDX_W-1:0]]       <= item.value;
      query_symbol_flag[query_count[AIDX_W-1:0]] <= item.is_symbol;
    end
    if (take && is_atom) begin
      line_distance <= dist_upd;
    end
  end

endmodule

// ===== src/krbm_best_select.sv =====
// best line tracking and result register
module krbm_best_select (
  input  logic               clk,
  input  logic               rst,
  input  krbm_pkg::krbm_tok_t tok,
  output logic               hold,
  krbm_out_if.source         result
);
  import krbm_pkg::*;

  logic                            best_found;
  logic [LINE_W-1:0]               best_index;
  logic [MAX_ARGS-1:0][DIST_W-1:0] best_distance;
  logic                            better;

  // lexicographic compare, first differing ranked argument decides
  always_comb begin
    better = 1'b0;
    for (int j = MAX_ARGS - 1; j >= 0; j--) begin
      if (tok.rank[j] && (tok.distance[j] != best_distance[j])) begin
        better = tok.distance[j] < best_distance[j];
      end
    end
  end

  assign hold = (tok.kind == TOK_FINISH) && result.valid && !result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (!hold && (tok.kind == TOK_FINISH)) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (!hold) begin
        case (tok.kind)
          TOK_RESTART: begin
            best_found <= 1'b0;
          end
          TOK_CLOSE: begin
            if (tok.hit && (!best_found || better)) begin
              best_found    <= 1'b1;
              best_index    <= tok.line;
              best_distance <= tok.distance;
            end
          end
          TOK_FINISH: begin
            result.best_line <= best_found ? BEST_W'(best_index) : '1;
            result.overflow  <= tok.overflow;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== src/keyed_record_best_match_search_unit.sv =====
// top level of the keyed record best match search unit
//
//   channel   direction  transfer when          payload
//   request   in         valid && ready         kind, is_symbol, value, end_of_line
//   result    out        valid && ready         best_line, overflow
//   cfg       in         cfg_write              cfg_index, cfg_data
//
// one item per cycle sustained while no finish is held; a finish passes the input
// register, the line evaluation token and then the result register
// reset clears the query count, line state, best found flag and keys (key count 1)
// a result held at the output stalls a finish in the token stage; items behind
// it fill the input register, then ready drops
module keyed_record_best_match_search_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [krbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [krbm_pkg::CFG_DATA_W-1:0]    cfg_data,
  krbm_in_if.sink                            request,
  krbm_out_if.source                         result
);
  import krbm_pkg::*;

  krbm_cfg_t  cfg;
  logic       s1_valid;
  krbm_item_t s1_item;
  logic       take;
  logic       hold;
  krbm_tok_t  tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_count <= KCNT_W'(1);
      cfg.key       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_COUNT: cfg.key_count <= cfg_data[KCNT_W-1:0];
        CFG_KEY_0:     cfg.key[0]    <= cfg_data[KEY_W-1:0];
        CFG_KEY_1:     cfg.key[1]    <= cfg_data[KEY_W-1:0];
        CFG_KEY_2:     cfg.key[2]    <= cfg_data[KEY_W-1:0];
        CFG_KEY_3:     cfg.key[3]    <= cfg_data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  assign request.ready = !s1_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.valid && request.ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_item.kind        <= request.kind;
      s1_item.is_symbol   <= request.is_symbol;
      s1_item.value       <= request.value;
      s1_item.end_of_line <= request.end_of_line;
    end
  end

  krbm_line_eval u_line_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (s1_valid),
    .item       (s1_item),
    .hold       (hold),
    .take       (take),
    .tok        (tok)
  );

  krbm_best_select u_best_select (
    .clk    (clk),
    .rst    (rst),
    .tok    (tok),
    .hold   (hold),
    .result (result)
  );

`ifndef SYNTHESIS
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(tok.kind == TOK_FINISH))
    else $error("result raised without a finish token");

  a_hold_keeps_finish: assert property (@(posedge clk) disable iff (rst)
    hold |=> (tok.kind == TOK_FINISH))
    else $error("stalled finish token lost");

  a_hold_blocks_take: assert property (@(posedge clk) disable iff (rst)
    hold |-> !take)
    else $error("item taken while token stage is held");

  a_best_line_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.best_line[BEST_W-1] || (result.best_line == '1)))
    else $error("best line neither an index nor minus one");
`endif

endmodule

// ===== tb/keyed_record_best_match_search_unit_tb.sv =====
// self-checking testbench for the keyed record best match search unit: directed and random searches
module keyed_record_best_match_search_unit_tb;
  import krbm_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_PCT      = 31;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_CYCLES  = 120;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASES        = 8;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int MAX_REPORTS   = 200;

  localparam logic [KIND_W-1:0]  FIRST_UNUSED_KIND = KIND_W'(KIND_FINISH + 1);
  localparam logic [KIND_W-1:0]  LAST_KIND         = '1;
  localparam logic [VALUE_W-1:0] MOST_NEGATIVE     = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] MOST_POSITIVE     = 32'h7FFF_FFFF;

  typedef struct {
    logic signed [BEST_W-1:0] best_line;
    logic                     overflow;
  } search_report_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  krbm_in_if  req_ch();
  krbm_out_if res_ch();

  keyed_record_best_match_search_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .request(req_ch),
    .result(res_ch)
  );

  // search unit mirror
  logic [KCNT_W-1:0]   cfg_key_count;
  logic [KEY_W-1:0]    cfg_key [MAX_KEYS];
  logic [VALUE_W-1:0]  arg_value [MAX_ARGS];
  logic                arg_is_sym [MAX_ARGS];
  int                  arg_count;
  logic [MAX_ARGS-1:0] args_hit;
  logic                line_pass;
  logic [VALUE_W:0]    line_dist [MAX_ARGS];
  logic [VALUE_W:0]    best_dist [MAX_ARGS];
  int                  best_line_idx;
  int                  lines_counted;
  int                  atom_pos;
  logic                overflow_seen;

  search_report_t awaited_reports [$];
  int             errors = 0;
  int             items_sent = 0;
  bit             idle_on = 1'b1;
  int             stall_req = 0;

  always #HALF_PERIOD clk = ~clk;

  function automatic int active_keys();
    int k;
    k = int'(cfg_key_count);
    if (k < 1) k = 1;
    if (k > MAX_KEYS) k = MAX_KEYS;
    return k;
  endfunction

  function automatic void arg_slot(input int j, output int field, output logic [OP_W-1:0] op);
    int kc;
    logic [KEY_W-1:0] k;
    kc = active_keys();
    k = (j < kc) ? cfg_key[j] : cfg_key[kc-1];
    field = int'(k[FIELD_W-1:0]);
    if (j >= kc) field += j - kc + 1;
    op = k[KEY_W-1:FIELD_W];
  endfunction

  function automatic void restart_lines();
    args_hit = '0;
    line_pass = 1'b1;
    best_line_idx = -1;
    lines_counted = 0;
    atom_pos = 0;
  endfunction

  function automatic void score_atom(input logic sym, input logic [VALUE_W-1:0] raw);
    int field;
    logic [OP_W-1:0] op;
    longint a;
    longint q;
    longint d;
    bit pass;
    for (int j = 0; j < arg_count; j++) begin
      arg_slot(j, field, op);
      if (field == atom_pos) begin
        args_hit[j] = 1'b1;
        if (sym != arg_is_sym[j]) begin
          line_pass = 1'b0;
        end else if (sym) begin
          if (op != OP_EQ || raw != arg_value[j]) line_pass = 1'b0;
        end else begin
          a = longint'($signed(raw));
          q = longint'($signed(arg_value[j]));
          case (op)
            OP_EQ: pass = (a == q);
            OP_GT: pass = (a > q);
            OP_GE: pass = (a >= q);
            OP_LT: pass = (a < q);
            OP_LE: pass = (a <= q);
            default: pass = 1'b1;
          endcase
          if (!pass) line_pass = 1'b0;
          d = (a >= q) ? a - q : q - a;
          line_dist[j] = d[VALUE_W:0];
        end
      end
    end
  endfunction

  function automatic bit beats_best();
    int field;
    logic [OP_W-1:0] op;
    for (int j = 0; j < arg_count; j++) begin
      arg_slot(j, field, op);
      if (arg_is_sym[j] || op == OP_EQ) continue;
      if (line_dist[j] < best_dist[j]) return 1'b1;
      if (line_dist[j] > best_dist[j]) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic void close_record();
    logic [MAX_ARGS-1:0] need;
    need = ~({MAX_ARGS{1'b1}} << arg_count);
    if (lines_counted >= MAX_LINES) begin
      overflow_seen = 1'b1;
    end else begin
      if (line_pass && (args_hit & need) == need && (best_line_idx < 0 || beats_best())) begin
        best_line_idx = lines_counted;
        best_dist = line_dist;
      end
      lines_counted++;
    end
    args_hit = '0;
    line_pass = 1'b1;
    atom_pos = 0;
  endfunction

  function automatic void apply_item(input logic [KIND_W-1:0] kind, input logic sym,
                                     input logic [VALUE_W-1:0] raw, input logic eol);
    search_report_t report;
    case (kind)
      KIND_START: begin
        arg_count = 0;
        overflow_seen = 1'b0;
        restart_lines();
      end
      KIND_ARG: begin
        if (arg_count >= MAX_ARGS) begin
          overflow_seen = 1'b1;
        end else begin
          arg_value[arg_count] = raw;
          arg_is_sym[arg_count] = sym;
          arg_count++;
          restart_lines();
        end
      end
      KIND_ATOM: begin
        if (atom_pos < MAX_LINE_ATOMS) begin
          score_atom(sym, raw);
          atom_pos++;
        end
        if (eol) close_record();
      end
      KIND_EMPTY: close_record();
      KIND_FINISH: begin
        report.best_line = best_line_idx[BEST_W-1:0];
        report.overflow = overflow_seen;
        awaited_reports.push_back(report);
      end
      default: ;
    endcase
  endfunction

  function automatic int record_span();
    int field;
    int widest;
    logic [OP_W-1:0] op;
    widest = 1;
    for (int j = 0; j < arg_count; j++) begin
      arg_slot(j, field, op);
      if (field + 1 > widest) widest = field + 1;
    end
    return widest;
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [KEY_W-1:0] key_of(input logic [OP_W-1:0] op, input int field);
    return {op, FIELD_W'(field)};
  endfunction

  function automatic logic [VALUE_W-1:0] number_value();
    case ($urandom_range(0, 9))
      0: return MOST_NEGATIVE;
      1: return MOST_POSITIVE;
      2: return '0;
      3, 4: return $urandom;
      default: return ($urandom_range(0, 64) - 32) << 14;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] symbol_id();
    return ($urandom_range(99) < 80) ? $urandom_range(0, 15) : $urandom;
  endfunction

  // atom value that usually passes the operator, with small distances so ties happen
  function automatic logic [VALUE_W-1:0] near_value(input logic [VALUE_W-1:0] q,
                                                    input logic [OP_W-1:0] op);
    logic [VALUE_W-1:0] delta;
    delta = $urandom_range(1, 4);
    if ($urandom_range(99) < 15) return q + $urandom_range(0, 8) - 4;
    case (op)
      OP_EQ: return q;
      OP_GT: return q + delta;
      OP_GE: return q + delta - 1;
      OP_LT: return q - delta;
      OP_LE: return q - delta + 1;
      default: return any_bit() ? q + delta - 1 : q - delta + 1;
    endcase
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input logic sym,
                           input logic [VALUE_W-1:0] raw, input logic eol);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.is_symbol <= sym;
    req_ch.value <= raw;
    req_ch.end_of_line <= eol;
    do @(posedge clk); while (!req_ch.ready);
    apply_item(kind, sym, raw, eol);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_atom(input logic eol);
    int field;
    int hit;
    logic [OP_W-1:0] op;
    logic [OP_W-1:0] hit_op;
    logic sym;
    logic [VALUE_W-1:0] v;
    hit = -1;
    hit_op = OP_EQ;
    for (int j = arg_count - 1; j >= 0; j--) begin
      arg_slot(j, field, op);
      if (field == atom_pos) begin
        hit = j;
        hit_op = op;
      end
    end
    if (hit < 0 || $urandom_range(99) < 6) begin
      sym = ($urandom_range(99) < 25);
      v = sym ? symbol_id() : number_value();
    end else if (arg_is_sym[hit]) begin
      sym = 1'b1;
      v = ($urandom_range(99) < 80) ? arg_value[hit] : symbol_id();
    end else begin
      sym = 1'b0;
      v = near_value(arg_value[hit], hit_op);
    end
    send_item(KIND_ATOM, sym, v, eol);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic load_keys(input logic [KCNT_W-1:0] count, input logic [KEY_W-1:0] keys [MAX_KEYS]);
    write_reg(CFG_KEY_COUNT, CFG_DATA_W'(count));
    for (int i = 0; i < MAX_KEYS; i++) write_reg(cfg_idx_t'(CFG_KEY_0 + i), keys[i]);
    cfg_write <= 1'b0;
    cfg_key_count = count;
    cfg_key = keys;
  endtask

  task automatic send_random_line();
    int span;
    int len;
    int roll;
    bit close_by_empty;
    span = record_span();
    roll = $urandom_range(99);
    close_by_empty = ($urandom_range(99) < 6);
    if (roll < 5) len = 0;
    else if (roll < 13) len = $urandom_range(0, span - 1);
    else if (roll < 18) len = $urandom_range(MAX_LINE_ATOMS, MAX_LINE_ATOMS + 3);
    else len = span + (($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
    if (len == 0) close_by_empty = 1'b1;
    for (int p = 0; p < len; p++) send_atom(p == len - 1 && !close_by_empty);
    if (close_by_empty) send_item(KIND_EMPTY, any_bit(), $urandom, any_bit());
  endtask

  task automatic run_random_search();
    int n_args;
    int n_lines;
    if ($urandom_range(99) < 90) send_item(KIND_START, any_bit(), $urandom, any_bit());
    n_args = ($urandom_range(99) < 8) ? $urandom_range(MAX_ARGS + 1, MAX_ARGS + 2)
                                      : $urandom_range(1, MAX_ARGS);
    for (int i = 0; i < n_args; i++) begin
      if ($urandom_range(99) < 25) send_item(KIND_ARG, 1'b1, symbol_id(), any_bit());
      else send_item(KIND_ARG, 1'b0, number_value(), any_bit());
    end
    n_lines = $urandom_range(1, 6);
    for (int l = 0; l < n_lines; l++) begin
      send_random_line();
      if ($urandom_range(99) < 4) send_item(KIND_FINISH, any_bit(), $urandom, any_bit());
      if ($urandom_range(99) < 3)
        send_item(KIND_W'($urandom_range(0, LAST_KIND)), any_bit(), $urandom, any_bit());
    end
    // line left open across the finish
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 3)) send_atom(1'b0);
    send_item(KIND_FINISH, any_bit(), $urandom, any_bit());
  endtask

  task automatic test_finish_after_reset();
    send_item(KIND_FINISH, 1'b0, '0, 1'b0);
  endtask

  task automatic test_distance_extremes();
    drain_results();
    load_keys(KCNT_W'(2), '{key_of(OP_NEAR, 0), key_of(OP_LE, 1), '0, '0});
    send_item(KIND_START, 1'b0, '0, 1'b0);
    send_item(KIND_ARG, 1'b0, MOST_NEGATIVE, 1'b0);
    send_item(KIND_ARG, 1'b0, MOST_POSITIVE, 1'b0);
    send_item(KIND_ATOM, 1'b0, MOST_POSITIVE, 1'b0);
    send_item(KIND_ATOM, 1'b0, MOST_POSITIVE, 1'b1);
    send_item(KIND_ATOM, 1'b0, MOST_POSITIVE, 1'b0);
    send_item(KIND_ATOM, 1'b0, MOST_NEGATIVE, 1'b1);
    send_item(KIND_FINISH, 1'b0, '0, 1'b0);
  endtask

  task automatic test_symbols_and_arg_overflow();
    drain_results();
    load_keys(KCNT_W'(1), '{key_of(OP_EQ, 0), '0, '0, '0});
    send_item(KIND_START, 1'b0, '0, 1'b0);
    send_item(KIND_ARG, 1'b1, 32'd5, 1'b0);
    send_item(KIND_ARG, 1'b0, 32'h0003_0000, 1'b0);
    send_item(KIND_EMPTY, 1'b0, '0, 1'b0);
    send_item(KIND_ATOM, 1'b1, 32'd5, 1'b0);
    send_item(KIND_ATOM, 1'b0, 32'h0003_0000, 1'b1);
    send_item(KIND_FINISH, 1'b0, '0, 1'b0);
    repeat (MAX_ARGS - 1) send_item(KIND_ARG, 1'b0, number_value(), 1'b0);
    send_item(FIRST_UNUSED_KIND, 1'b1, $urandom, 1'b1);
    send_item(KIND_FINISH, 1'b0, '0, 1'b0);
  endtask

  task automatic test_random_searches();
    logic [KEY_W-1:0] keys [MAX_KEYS];
    logic [KCNT_W-1:0] count;
    int phase_end;
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          count = '0;
          keys = '{default: '0};
        end
        1: begin
          count = '1;
          keys = '{default: '1};
        end
        default: begin
          count = KCNT_W'($urandom_range(0, (1 << KCNT_W) - 1));
          for (int i = 0; i < MAX_KEYS; i++)
            keys[i] = {OP_W'($urandom_range(0, (1 << OP_W) - 1)),
                       FIELD_W'(($urandom_range(99) < 75) ? $urandom_range(0, 7)
                                                          : $urandom_range(0, 15))};
        end
      endcase
      load_keys(count, keys);
      idle_on = (phase != 3);
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) run_random_search();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_result_backpressure();
    drain_results();
    idle_on = 1'b0;
    stall_req++;
    send_item(KIND_FINISH, 1'b0, '0, 1'b0);
    repeat (6) begin
      send_atom(1'b1);
      send_item(KIND_FINISH, any_bit(), $urandom, any_bit());
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int stall_left;
    int stall_seen;
    stall_left = 0;
    stall_seen = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_seen != stall_req) begin
        stall_seen = stall_req;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_results
    search_report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result transfer: expected none, actual best_line %0d overflow %0b",
                   $time, res_ch.best_line, res_ch.overflow);
      end else begin
        want = awaited_reports.pop_front();
        if (res_ch.best_line !== want.best_line) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: best_line mismatch: expected %0d actual %0d",
                     $time, want.best_line, res_ch.best_line);
        end
        if (res_ch.overflow !== want.overflow) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: overflow mismatch: expected %0b actual %0b",
                     $time, want.overflow, res_ch.overflow);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.is_symbol = 1'b0;
    req_ch.value = '0;
    req_ch.end_of_line = 1'b0;
    cfg_key_count = KCNT_W'(1);
    cfg_key = '{default: '0};
    arg_value = '{default: '0};
    arg_is_sym = '{default: 1'b0};
    line_dist = '{default: '0};
    best_dist = '{default: '0};
    arg_count = 0;
    overflow_seen = 1'b0;
    restart_lines();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_finish_after_reset();
    test_distance_extremes();
    test_symbols_and_arg_overflow();
    test_random_searches();
    test_result_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("TB_ERROR");
    $finish;
  end

endmodule
